### rtl/pms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pms_pkg
// Types and constants shared by the PID motor speed loop and its arithmetic
// unit.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int unsigned UNIT_W    = 77;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned STEP_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(GAIN_W);
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(UNIT_W);

  localparam logic [19:0] STEP_NOMINAL = 20'd5243;
  localparam logic [19:0] STEP_MAXOK   = 20'd104857;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIM = 3'd4;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic {
    UOP_MUL,
    UOP_DIV
  } unit_op_e;

  typedef struct packed {
    logic              start;
    unit_op_e          op;
    logic [STEP_W-1:0] steps;
  } unit_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV_T,
    S_CLAMP,
    S_MUL_I,
    S_MUL_P,
    S_MUL_D,
    S_DIV_D,
    S_SUM,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

### rtl/pms_arith.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pms_arith
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module pms_arith (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pms_pkg::unit_cmd_t          cmd_i,
  input  wire logic [pms_pkg::UNIT_W-1:0]  opa_i,
  input  wire logic [pms_pkg::GAIN_W-1:0]  opb_i,
  output logic                             done_o,
  output logic [pms_pkg::UNIT_W-1:0]       result_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [pms_pkg::STEP_W-1:0]       cnt_q, cnt_d;
  pms_pkg::unit_op_e                op_q, op_d;
  logic [pms_pkg::UNIT_W-1:0]       a_q, a_d;
  logic [pms_pkg::UNIT_W-1:0]       acc_q, acc_d;
  logic [pms_pkg::GAIN_W-1:0]       b_q, b_d;
  logic [pms_pkg::GAIN_W:0]         trial;
  logic [pms_pkg::GAIN_W:0]         trial_sub;
  logic                             trial_ge;

  assign trial     = {acc_q[pms_pkg::GAIN_W-1:0], a_q[pms_pkg::UNIT_W-1]};
  assign trial_sub = trial - {1'b0, b_q};
  assign trial_ge  = trial >= {1'b0, b_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = cmd_i.steps;
      op_d   = cmd_i.op;
      a_d    = opa_i;
      b_d    = opb_i;
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == pms_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      case (op_q)
        pms_pkg::UOP_MUL: begin
          acc_d = b_q[0] ? acc_q + a_q : acc_q;
          a_d   = a_q << 1;
          b_d   = b_q >> 1;
        end
        pms_pkg::UOP_DIV: begin
          acc_d = trial_ge ? pms_pkg::UNIT_W'(trial_sub) : pms_pkg::UNIT_W'(trial);
          a_d   = {a_q[pms_pkg::UNIT_W-2:0], trial_ge};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= pms_pkg::UOP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o   = done_q;
  assign result_o = (op_q == pms_pkg::UOP_MUL) ? acc_q : a_q;

endmodule
`default_nettype wire

### rtl/pid_motor_speed_loop.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_motor_speed_loop
// Fixed-point PID speed loop with integral anti-windup and output clamp.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in       in   in_valid_i/in_stall_o operation, goal, measured, time_step
//  out      out  out_valid_o/out_stall_i command and three limit flags
//  cfg      in   cfg_we_i              cfg_index_i, cfg_data_i
//
//  An update runs on the one-bit-per-cycle shared multiply/divide unit
//  (up to two 77-step divides and up to three 24-step multiplies).
//  A clear skips the arithmetic. One item is in work at a time; in_stall_o is
//  high from accept until the result is loaded into the output register.
//  Reset clears the loop state and loads the default gains and limits.
// ----------------------------------------------------------------------------
module pid_motor_speed_loop #(
  parameter logic [15:0] DutyMaxDefault = 16'd4095
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pms_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pms_pkg::GAIN_W-1:0]        cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              operation_i,
  input  wire logic signed [31:0]                goal_i,
  input  wire logic signed [31:0]                measured_i,
  input  wire logic [19:0]                       time_step_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [16:0]                     command_o,
  output logic                                   step_replaced_o,
  output logic                                   integral_limited_o,
  output logic                                   output_limited_o
);

  logic [23:0] gain_p_q, gain_i_q, gain_d_q;
  logic [15:0] ilim_q, olim_q;

  pms_pkg::state_e state_q, state_d;
  logic            go_q;

  logic signed [32:0] prev_err_q;
  logic signed [63:0] integ_q;
  logic signed [32:0] err_q;
  logic signed [33:0] diff_q;
  logic [16:0]        dt_q;
  logic signed [50:0] prod_q;
  logic [51:0]        t_q;
  logic signed [33:0] iterm_q;
  logic signed [57:0] pterm_q;
  logic [56:0]        umd_q;
  logic signed [60:0] dterm_q;
  logic signed [61:0] sum_q;
  logic               repl_q, ilimf_q, clr_q;

  logic               out_valid_q;
  logic signed [16:0] cmd_q;
  logic               repl_out_q, ilim_out_q, olim_out_q;

  logic                       in_acc, out_load;
  logic                       u_done;
  logic [pms_pkg::UNIT_W-1:0] u_res;
  pms_pkg::unit_cmd_t         u_cmd;
  logic [pms_pkg::UNIT_W-1:0] u_opa;
  logic [pms_pkg::GAIN_W-1:0] u_opb;

  // input stage
  logic signed [32:0] err_d;
  logic signed [33:0] diff_d;
  logic [16:0]        dt_d;
  logic               repl_d;
  logic signed [17:0] dt_s;
  logic signed [50:0] prod_d;

  // integral update and clamp
  logic signed [63:0] prod_ext, isum, isat, t_pos;
  logic               iovf, above_t, below_t;
  logic [63:0]        is_mag;
  logic [32:0]        err_mag;
  logic [33:0]        diff_mag;
  logic [59:0]        dmag;

  // output clamp
  logic signed [61:0] lim_s;
  logic [61:0]        sum_mag;
  logic [15:0]        cmd_mag;
  logic signed [16:0] cmd_d;
  logic               olim_d;

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    repl_d = (time_step_i == '0) || (time_step_i > pms_pkg::STEP_MAXOK);
    dt_d   = repl_d ? pms_pkg::STEP_NOMINAL[16:0] : time_step_i[16:0];
    err_d  = {goal_i[31], goal_i} - {measured_i[31], measured_i};
    diff_d = {err_d[32], err_d} - {prev_err_q[32], prev_err_q};
    dt_s   = {1'b0, dt_d};
    prod_d = err_d * dt_s;
  end

  always_comb begin
    prod_ext = {{13{prod_q[50]}}, prod_q};
    isum     = integ_q + prod_ext;
    iovf     = (integ_q[63] == prod_ext[63]) && (isum[63] != integ_q[63]);
    if (iovf) begin
      isat = integ_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      isat = isum;
    end
    t_pos    = {12'd0, t_q};
    above_t  = integ_q > t_pos;
    below_t  = integ_q < -t_pos;
    is_mag   = integ_q[63] ? 64'(-integ_q) : 64'(integ_q);
    err_mag  = err_q[32] ? 33'(-err_q) : 33'(err_q);
    diff_mag = diff_q[33] ? 34'(-diff_q) : 34'(diff_q);
    dmag     = (u_res > pms_pkg::UNIT_W'(60'd1 << 59)) ? (60'd1 << 59) : u_res[59:0];
  end

  always_comb begin
    lim_s   = {30'd0, olim_q, 16'd0};
    sum_mag = sum_q[61] ? 62'(-sum_q) : 62'(sum_q);
    cmd_mag = sum_mag[31:16];
    olim_d  = 1'b0;
    if (clr_q) begin
      cmd_d = '0;
    end else if (sum_q > lim_s) begin
      cmd_d  = {1'b0, olim_q};
      olim_d = 1'b1;
    end else if (sum_q < -lim_s) begin
      cmd_d  = -$signed({1'b0, olim_q});
      olim_d = 1'b1;
    end else begin
      cmd_d = sum_q[61] ? -$signed({1'b0, cmd_mag}) : $signed({1'b0, cmd_mag});
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pms_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (operation_i == pms_pkg::OP_CLEAR) ? pms_pkg::S_OUT : pms_pkg::S_PREP;
        end
      end
      pms_pkg::S_PREP:  state_d = (gain_i_q != '0) ? pms_pkg::S_DIV_T : pms_pkg::S_MUL_P;
      pms_pkg::S_DIV_T: if (u_done) state_d = pms_pkg::S_CLAMP;
      pms_pkg::S_CLAMP: state_d = (above_t || below_t) ? pms_pkg::S_MUL_P : pms_pkg::S_MUL_I;
      pms_pkg::S_MUL_I: if (u_done) state_d = pms_pkg::S_MUL_P;
      pms_pkg::S_MUL_P: if (u_done) state_d = pms_pkg::S_MUL_D;
      pms_pkg::S_MUL_D: if (u_done) state_d = pms_pkg::S_DIV_D;
      pms_pkg::S_DIV_D: if (u_done) state_d = pms_pkg::S_SUM;
      pms_pkg::S_SUM:   state_d = pms_pkg::S_OUT;
      pms_pkg::S_OUT:   if (out_load) state_d = pms_pkg::S_IDLE;
      default:          state_d = pms_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o    = state_q != pms_pkg::S_IDLE;
    out_load      = (state_q == pms_pkg::S_OUT) && (!out_valid_q || !out_stall_i);
    u_cmd.start   = 1'b0;
    u_cmd.op      = pms_pkg::UOP_MUL;
    u_cmd.steps   = pms_pkg::MUL_STEPS;
    u_opa         = '0;
    u_opb         = '0;
    case (state_q)
      pms_pkg::S_DIV_T: begin
        u_cmd.start = go_q;
        u_cmd.op    = pms_pkg::UOP_DIV;
        u_cmd.steps = pms_pkg::DIV_STEPS;
        u_opa       = pms_pkg::UNIT_W'({ilim_q, 36'd0});
        u_opb       = gain_i_q;
      end
      pms_pkg::S_MUL_I: begin
        u_cmd.start = go_q;
        u_opa       = pms_pkg::UNIT_W'(is_mag[51:0]);
        u_opb       = gain_i_q;
      end
      pms_pkg::S_MUL_P: begin
        u_cmd.start = go_q;
        u_opa       = pms_pkg::UNIT_W'(err_mag);
        u_opb       = gain_p_q;
      end
      pms_pkg::S_MUL_D: begin
        u_cmd.start = go_q;
        u_opa       = pms_pkg::UNIT_W'(diff_mag);
        u_opb       = gain_d_q;
      end
      pms_pkg::S_DIV_D: begin
        u_cmd.start = go_q;
        u_cmd.op    = pms_pkg::UOP_DIV;
        u_cmd.steps = pms_pkg::DIV_STEPS;
        u_opa       = {umd_q, 20'd0};
        u_opb       = {7'd0, dt_q};
      end
      default: ;
    endcase
  end

  pms_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (u_cmd),
    .opa_i    (u_opa),
    .opb_i    (u_opb),
    .done_o   (u_done),
    .result_o (u_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= 24'd79954;
      gain_i_q    <= 24'd589824;
      gain_d_q    <= 24'd0;
      ilim_q      <= DutyMaxDefault;
      olim_q      <= DutyMaxDefault;
      state_q     <= pms_pkg::S_IDLE;
      go_q        <= 1'b0;
      prev_err_q  <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pms_pkg::CFG_GAIN_P:     gain_p_q <= cfg_data_i;
          pms_pkg::CFG_GAIN_I:     gain_i_q <= cfg_data_i;
          pms_pkg::CFG_GAIN_D:     gain_d_q <= cfg_data_i;
          pms_pkg::CFG_INTEG_LIM:  ilim_q   <= cfg_data_i[15:0];
          pms_pkg::CFG_OUTPUT_LIM: olim_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      state_q <= state_d;
      go_q    <= state_d != state_q;
      if (in_acc) begin
        if (operation_i == pms_pkg::OP_CLEAR) begin
          prev_err_q <= '0;
          integ_q    <= '0;
        end else begin
          prev_err_q <= err_d;
        end
      end
      if (state_q == pms_pkg::S_PREP) begin
        integ_q <= isat;
      end
      if (state_q == pms_pkg::S_CLAMP) begin
        if (above_t) begin
          integ_q <= t_pos;
        end else if (below_t) begin
          integ_q <= -t_pos;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      clr_q  <= operation_i == pms_pkg::OP_CLEAR;
      err_q  <= err_d;
      diff_q <= diff_d;
      dt_q   <= dt_d;
      repl_q <= repl_d;
      prod_q <= prod_d;
    end
    case (state_q)
      pms_pkg::S_PREP: begin
        iterm_q <= '0;
        ilimf_q <= 1'b0;
      end
      pms_pkg::S_DIV_T: if (u_done) t_q <= u_res[51:0];
      pms_pkg::S_CLAMP: begin
        if (above_t) begin
          iterm_q <= $signed({2'd0, ilim_q, 16'd0});
          ilimf_q <= 1'b1;
        end else if (below_t) begin
          iterm_q <= -$signed({2'd0, ilim_q, 16'd0});
          ilimf_q <= 1'b1;
        end
      end
      pms_pkg::S_MUL_I: begin
        if (u_done) begin
          iterm_q <= integ_q[63] ? -$signed({1'b0, u_res[52:20]})
                                 : $signed({1'b0, u_res[52:20]});
        end
      end
      pms_pkg::S_MUL_P: begin
        if (u_done) begin
          pterm_q <= err_q[32] ? -$signed({1'b0, u_res[56:0]})
                               : $signed({1'b0, u_res[56:0]});
        end
      end
      pms_pkg::S_MUL_D: if (u_done) umd_q <= u_res[56:0];
      pms_pkg::S_DIV_D: begin
        if (u_done) begin
          dterm_q <= diff_q[33] ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
        end
      end
      pms_pkg::S_SUM: begin
        sum_q <= {{4{pterm_q[57]}}, pterm_q} + {{28{iterm_q[33]}}, iterm_q}
               + {dterm_q[60], dterm_q};
      end
      default: ;
    endcase
    if (out_load) begin
      cmd_q      <= cmd_d;
      repl_out_q <= repl_q && !clr_q;
      ilim_out_q <= ilimf_q && !clr_q;
      olim_out_q <= olim_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign command_o          = cmd_q;
  assign step_replaced_o    = repl_out_q;
  assign integral_limited_o = ilim_out_q;
  assign output_limited_o   = olim_out_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted beat did not stall the input");

  a_done_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> (state_q == pms_pkg::S_DIV_T || state_q == pms_pkg::S_MUL_I ||
                state_q == pms_pkg::S_MUL_P || state_q == pms_pkg::S_MUL_D ||
                state_q == pms_pkg::S_DIV_D))
    else $error("arithmetic unit finished outside a compute state");

  a_cmd_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($signed({1'b0, command_o[16] ? 17'(-command_o) : command_o})
                            <= $signed({2'b0, olim_q})))
    else $error("command exceeds output limit");

endmodule
`default_nettype wire
